// ----- sv/srdq_pkg.sv -----
`default_nettype none
package srdq_pkg;

  localparam logic [14:0] FULL_SCALE = 15'd32767;
  localparam logic [14:0] DZ_MAX     = 15'd32766;
  localparam logic [14:0] DZ_RESET   = 15'd3932;

  localparam int SQ_W  = 48;
  localparam int MAG_W = 24;
  localparam int N_W   = 56;
  localparam int D_W   = 40;
  localparam int Q_W   = 17;

  typedef struct packed {
    logic        sx;
    logic        sy;
    logic [15:0] ax;
    logic [15:0] ay;
  } axis_side_t;

  typedef struct packed {
    logic sx;
    logic sy;
    logic zero;
  } div_side_t;

endpackage
`default_nettype wire

// ----- sv/srdq_if.sv -----
`default_nettype none
interface srdq_stick_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] stick_x;
  logic signed [15:0] stick_y;
  modport source (output valid, output stick_x, output stick_y, input ready);
  modport sink (input valid, input stick_x, input stick_y, output ready);
endinterface

interface srdq_axes_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  modport source (output valid, output out_x, output out_y, input ready);
  modport sink (input valid, input out_x, input out_y, output ready);
endinterface

interface srdq_cfg_if;
  logic        valid;
  logic        ready;
  logic [14:0] deadzone_counts;
  modport source (output valid, output deadzone_counts, input ready);
  modport sink (input valid, input deadzone_counts, output ready);
endinterface
`default_nettype wire

// ----- sv/srdq_sqrt.sv -----
`default_nettype none
module srdq_sqrt (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         valid_i,
  input  wire logic [srdq_pkg::SQ_W-1:0]    val_i,
  input  wire srdq_pkg::axis_side_t         side_i,
  output logic                              valid_o,
  output logic [srdq_pkg::MAG_W-1:0]        mag_o,
  output srdq_pkg::axis_side_t              side_o
);
  import srdq_pkg::*;

  logic [SQ_W-1:0] v_r   [0:MAG_W];
  logic [SQ_W-1:0] res_r [0:MAG_W];
  logic            vld_r [0:MAG_W];
  axis_side_t      side_r [0:MAG_W];

  always_comb begin
    v_r[0]    = val_i;
    res_r[0]  = '0;
    vld_r[0]  = valid_i;
    side_r[0] = side_i;
  end

  // one result bit per stage
  for (genvar k = 0; k < MAG_W; k++) begin : g_stage
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
    logic [SQ_W:0]   trial;
    logic [SQ_W-1:0] v_nxt;
    logic [SQ_W-1:0] res_nxt;

    always_comb begin
      trial = {1'b0, res_r[k]} + {1'b0, BIT};
      if ({1'b0, v_r[k]} >= trial) begin
        v_nxt   = v_r[k] - trial[SQ_W-1:0];
        res_nxt = (res_r[k] >> 1) + BIT;
      end else begin
        v_nxt   = v_r[k];
        res_nxt = res_r[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_r[k+1]    <= v_nxt;
        res_r[k+1]  <= res_nxt;
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign valid_o = vld_r[MAG_W];
  assign mag_o   = res_r[MAG_W][MAG_W-1:0];
  assign side_o  = side_r[MAG_W];

endmodule
`default_nettype wire

// ----- sv/srdq_div.sv -----
`default_nettype none
module srdq_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       valid_i,
  input  wire logic [srdq_pkg::N_W-1:0]   nx_i,
  input  wire logic [srdq_pkg::N_W-1:0]   ny_i,
  input  wire logic [srdq_pkg::D_W-1:0]   d_i,
  input  wire srdq_pkg::div_side_t        side_i,
  output logic                            valid_o,
  output logic [srdq_pkg::Q_W-1:0]        qx_o,
  output logic [srdq_pkg::Q_W-1:0]        qy_o,
  output srdq_pkg::div_side_t             side_o
);
  import srdq_pkg::*;

  logic [N_W-1:0] rx_r  [0:Q_W];
  logic [N_W-1:0] ry_r  [0:Q_W];
  logic [D_W-1:0] d_r   [0:Q_W];
  logic [Q_W-1:0] qx_r  [0:Q_W];
  logic [Q_W-1:0] qy_r  [0:Q_W];
  logic           vld_r [0:Q_W];
  div_side_t      side_r [0:Q_W];

  always_comb begin
    rx_r[0]   = nx_i;
    ry_r[0]   = ny_i;
    d_r[0]    = d_i;
    qx_r[0]   = '0;
    qy_r[0]   = '0;
    vld_r[0]  = valid_i;
    side_r[0] = side_i;
  end

  // restoring division, msb of quotient first
  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int SH = Q_W - 1 - k;
    logic [N_W:0]   ds;
    logic           gx;
    logic           gy;
    logic [N_W-1:0] rx_nxt;
    logic [N_W-1:0] ry_nxt;

    always_comb begin
      ds     = (N_W+1)'(d_r[k]) << SH;
      gx     = {1'b0, rx_r[k]} >= ds;
      gy     = {1'b0, ry_r[k]} >= ds;
      rx_nxt = gx ? rx_r[k] - ds[N_W-1:0] : rx_r[k];
      ry_nxt = gy ? ry_r[k] - ds[N_W-1:0] : ry_r[k];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rx_r[k+1]   <= rx_nxt;
        ry_r[k+1]   <= ry_nxt;
        d_r[k+1]    <= d_r[k];
        qx_r[k+1]   <= {qx_r[k][Q_W-2:0], gx};
        qy_r[k+1]   <= {qy_r[k][Q_W-2:0], gy};
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign valid_o = vld_r[Q_W];
  assign qx_o    = qx_r[Q_W];
  assign qy_o    = qy_r[Q_W];
  assign side_o  = side_r[Q_W];

endmodule
`default_nettype wire

// ----- sv/stick_radial_deadzone_quantizer.sv -----
// radial deadzone and rescale for one analog stick sample
// in_stick: stick_x / stick_y samples, transfer on valid && ready
// out_axes: deadzoned, radially rescaled out_x / out_y, one per sample
// cfg_wr: deadzone_counts write, always ready, write only while idle
// throughput: one sample per cycle while the output is not stalled; the pipeline runs 24 square root
//   stages (one root bit each) and 17 divider stages (one quotient bit each)
// the whole pipeline advances together: when the output holds a result
//   that is not taken, every stage holds and in_stick.ready drops
// reset clears all valid bits and loads the deadzone with 3932
// a deadzone of 32767 acts as 32766
`default_nettype none
module stick_radial_deadzone_quantizer (
  input  wire logic  clk,
  input  wire logic  rst_n,
  srdq_stick_if.sink in_stick,
  srdq_axes_if.source out_axes,
  srdq_cfg_if.sink   cfg_wr
);
  import srdq_pkg::*;

  logic en;

  logic [14:0] dz_r;

  logic        v0_r;
  axis_side_t  s0_r;
  logic        v1_r;
  axis_side_t  s1_r;
  logic [31:0] sqx_r;
  logic [31:0] sqy_r;
  logic        v2_r;
  axis_side_t  s2_r;
  logic [31:0] sq_r;

  logic             sq_vld;
  logic [MAG_W-1:0] mag;
  axis_side_t       sq_side;

  logic        v3_r;
  div_side_t   s3_r;
  logic [22:0] num_r;
  logic [38:0] den3_r;
  logic [30:0] kx_r;
  logic [30:0] ky_r;

  logic        v4_r;
  div_side_t   s4_r;
  logic [53:0] nx_r;
  logic [53:0] ny_r;
  logic [38:0] den4_r;

  logic           v5_r;
  div_side_t      s5_r;
  logic [N_W-1:0] bx_r;
  logic [N_W-1:0] by_r;
  logic [D_W-1:0] d5_r;

  logic           dv_vld;
  logic [Q_W-1:0] qx;
  logic [Q_W-1:0] qy;
  div_side_t      dv_side;

  logic        ov_r;
  logic [15:0] ox_r;
  logic [15:0] oy_r;

  logic [14:0] dz;
  logic [22:0] dzq;
  logic [14:0] rng;
  logic [22:0] span;
  logic [23:0] diff;
  logic [22:0] num_nxt;
  logic [15:0] ox_nxt;
  logic [15:0] oy_nxt;

  assign en             = !ov_r || out_axes.ready;
  assign in_stick.ready = en;
  assign cfg_wr.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_r <= DZ_RESET;
    end else if (cfg_wr.valid) begin
      dz_r <= cfg_wr.deadzone_counts;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_stick.valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= sq_vld;
      v4_r <= v3_r;
      v5_r <= v4_r;
      ov_r <= dv_vld;
    end
  end

  // absolute values, squares, sum
  always_ff @(posedge clk) begin
    if (en) begin
      s0_r.sx <= in_stick.stick_x[15];
      s0_r.sy <= in_stick.stick_y[15];
      s0_r.ax <= in_stick.stick_x[15] ? 16'(~in_stick.stick_x + 16'd1) : in_stick.stick_x;
      s0_r.ay <= in_stick.stick_y[15] ? 16'(~in_stick.stick_y + 16'd1) : in_stick.stick_y;
      s1_r    <= s0_r;
      sqx_r   <= 32'(s0_r.ax) * 32'(s0_r.ax);
      sqy_r   <= 32'(s0_r.ay) * 32'(s0_r.ay);
      s2_r    <= s1_r;
      sq_r    <= sqx_r + sqy_r;
    end
  end

  srdq_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (v2_r),
    .val_i   ({sq_r, 16'd0}),
    .side_i  (s2_r),
    .valid_o (sq_vld),
    .mag_o   (mag),
    .side_o  (sq_side)
  );

  // deadzone test and rescale terms
  always_comb begin
    dz      = (dz_r > DZ_MAX) ? DZ_MAX : dz_r;
    dzq     = {dz, 8'd0};
    rng     = FULL_SCALE - dz;
    span    = {rng, 8'd0};
    diff    = mag - {1'b0, dzq};
    num_nxt = (diff > {1'b0, span}) ? span : diff[22:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r.sx   <= sq_side.sx;
      s3_r.sy   <= sq_side.sy;
      s3_r.zero <= mag <= {1'b0, dzq};
      num_r     <= num_nxt;
      den3_r    <= 39'(rng) * 39'(mag);
      kx_r      <= (31'(sq_side.ax) << 15) - 31'(sq_side.ax);
      ky_r      <= (31'(sq_side.ay) << 15) - 31'(sq_side.ay);
      s4_r      <= s3_r;
      nx_r      <= 54'(kx_r) * 54'(num_r);
      ny_r      <= 54'(ky_r) * 54'(num_r);
      den4_r    <= den3_r;
      s5_r      <= s4_r;
      bx_r      <= (N_W'(nx_r) << 1) + N_W'(den4_r);
      by_r      <= (N_W'(ny_r) << 1) + N_W'(den4_r);
      d5_r      <= D_W'(den4_r) << 1;
    end
  end

  srdq_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (v5_r),
    .nx_i    (bx_r),
    .ny_i    (by_r),
    .d_i     (d5_r),
    .side_i  (s5_r),
    .valid_o (dv_vld),
    .qx_o    (qx),
    .qy_o    (qy),
    .side_o  (dv_side)
  );

  // saturate, apply sign, zero inside the deadzone
  always_comb begin
    ox_nxt = (qx > Q_W'(FULL_SCALE)) ? 16'(FULL_SCALE) : qx[15:0];
    oy_nxt = (qy > Q_W'(FULL_SCALE)) ? 16'(FULL_SCALE) : qy[15:0];
    if (dv_side.sx) begin
      ox_nxt = 16'(~ox_nxt + 16'd1);
    end
    if (dv_side.sy) begin
      oy_nxt = 16'(~oy_nxt + 16'd1);
    end
    if (dv_side.zero) begin
      ox_nxt = '0;
      oy_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ox_r <= ox_nxt;
      oy_r <= oy_nxt;
    end
  end

  assign out_axes.valid = ov_r;
  assign out_axes.out_x = ox_r;
  assign out_axes.out_y = oy_r;

`ifndef ASSERT_OFF
  a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_axes.valid |-> out_axes.out_x != 16'sh8000 && out_axes.out_y != 16'sh8000)
    else $error("output outside +-32767");

  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_axes.valid && !out_axes.ready |-> !in_stick.ready)
    else $error("input taken while output stalled");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_axes.valid && !out_axes.ready |=> $stable(ox_r) && $stable(oy_r) && ov_r)
    else $error("stalled result changed");
`endif

endmodule
`default_nettype wire

// ----- test/tb_stick_radial_deadzone_quantizer.sv -----
`timescale 1ns / 100ps
module tb_stick_radial_deadzone_quantizer;
  import srdq_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #10 clk = ~clk;

  srdq_stick_if in_stick();
  srdq_axes_if  out_axes();
  srdq_cfg_if   cfg_wr();

  stick_radial_deadzone_quantizer DUT (
    .clk(clk), .rst_n(rst_n), .in_stick(in_stick.sink), .out_axes(out_axes.source),
    .cfg_wr(cfg_wr.sink)
  );

  typedef struct {
    logic signed [15:0] ox;
    logic signed [15:0] oy;
  } axes_t;

  localparam int EXP_DEPTH = 2048;
  axes_t expected_axes[EXP_DEPTH];
  int exp_wr = 0;
  int exp_rd = 0;
  logic [14:0] deadzone = DZ_RESET;
  int errors = 0;
  int results_seen = 0;
  int samples_sent = 0;
  int cycles = 0;
  int hold_off = 0;
  bit stall_enable = 1'b1;
  localparam int LIMIT = 600000;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] rescale_axis(input logic signed [15:0] v,
                                                input logic [63:0] num,
                                                input logic [63:0] den);
    logic [63:0] a;
    logic [127:0] n;
    logic [127:0] q;
    a = v[15] ? 64'(-32'(v)) : 64'(v);
    n = 128'(a) * 128'(FULL_SCALE) * 128'(num);
    q = (2 * n + 128'(den)) / (2 * 128'(den));
    if (q > 128'(FULL_SCALE)) q = 128'(FULL_SCALE);
    return v[15] ? 16'(-q) : q[15:0];
  endfunction

  function automatic axes_t predict_axes(input logic signed [15:0] x,
                                         input logic signed [15:0] y);
    axes_t r;
    logic [63:0] dz, ax, ay, mag, dzq, span, num, den;
    dz = (deadzone > DZ_MAX) ? 64'(DZ_MAX) : 64'(deadzone);
    ax = x[15] ? 64'(-32'(x)) : 64'(x);
    ay = y[15] ? 64'(-32'(y)) : 64'(y);
    mag = int_sqrt((ax * ax + ay * ay) << 16);
    dzq = dz << 8;
    r.ox = 0;
    r.oy = 0;
    if (mag > dzq) begin
      span = (64'(FULL_SCALE) - dz) << 8;
      num = mag - dzq;
      if (num > span) num = span;
      den = (64'(FULL_SCALE) - dz) * mag;
      r.ox = rescale_axis(x, num, den);
      r.oy = rescale_axis(y, num, den);
    end
    return r;
  endfunction

  initial begin
    in_stick.valid = 1'b0;
    in_stick.stick_x = '0;
    in_stick.stick_y = '0;
    out_axes.ready = 1'b0;
    cfg_wr.valid = 1'b0;
    cfg_wr.deadzone_counts = '0;
  end

  // receiver stall pattern plus long hold-off
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_axes.ready <= 1'b0;
    end else if (!stall_enable) begin
      out_axes.ready <= 1'b1;
    end else begin
      out_axes.ready <= (cycles % 23 < 15) ? ($urandom_range(0, 3) != 0) : 1'b1;
    end
  end

  always @(posedge clk) begin
    axes_t e;
    if (rst_n && out_axes.valid && out_axes.ready) begin
      results_seen <= results_seen + 1;
      if (exp_wr == exp_rd) begin
        $error("unexpected transfer out_x=%0d out_y=%0d", out_axes.out_x, out_axes.out_y);
        errors++;
      end else begin
        e = expected_axes[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (out_axes.out_x !== e.ox) begin
          $error("out_x expected %0d actual %0d", e.ox, out_axes.out_x);
          errors++;
        end
        if (out_axes.out_y !== e.oy) begin
          $error("out_y expected %0d actual %0d", e.oy, out_axes.out_y);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("stick_radial_deadzone_quantizer regression: fail");
      $finish;
    end
  end

  task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] y);
    in_stick.valid <= 1'b1;
    in_stick.stick_x <= x;
    in_stick.stick_y <= y;
    @(posedge clk);
    while (!in_stick.ready) @(posedge clk);
    expected_axes[exp_wr % EXP_DEPTH] = predict_axes(x, y);
    exp_wr++;
    samples_sent++;
  endtask

  task automatic idle_sender(input int n);
    in_stick.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    idle_sender(1);
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_deadzone(input logic [14:0] v);
    cfg_wr.valid <= 1'b1;
    cfg_wr.deadzone_counts <= v;
    @(posedge clk);
    while (!cfg_wr.ready) @(posedge clk);
    cfg_wr.valid <= 1'b0;
    deadzone = v;
    @(posedge clk);
  endtask

  task automatic random_burst(input int n);
    int burst;
    int k;
    logic [15:0] x, y;
    k = 0;
    while (k < n) begin
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        case ($urandom_range(0, 4))
          0: begin x = $urandom; y = $urandom; end
          1: begin x = $urandom_range(0, 8000) - 4000; y = $urandom_range(0, 8000) - 4000; end
          2: begin x = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff; y = $urandom; end
          3: begin x = $urandom; y = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff; end
          default: begin x = $urandom_range(0, 600) - 300; y = $urandom; end
        endcase
        send_sample(x, y);
        k++;
      end
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 8));
    end
  endtask

  task automatic test_directed_extremes();
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sd32767, 16'sd0);
    send_sample(-16'sd32768, 16'sd0);
    send_sample(16'sd0, -16'sd32768);
    send_sample(-16'sd32768, -16'sd32768);
    send_sample(16'sd32767, 16'sd32767);
    send_sample(16'sd3932, 16'sd0);
    send_sample(16'sd3933, 16'sd0);
    send_sample(16'sd2780, 16'sd2781);
    send_sample(-16'sd1, 16'sd1);
    send_sample(16'sd23170, -16'sd23170);
    send_sample(16'sh5555, 16'shaaaa);
    wait_drained();
  endtask

  task automatic test_deadzone_settings();
    logic [14:0] dz_list[6] = '{15'd0, 15'd32766, 15'd32767, 15'd1, 15'h2aaa, 15'h5555};
    foreach (dz_list[i]) begin
      write_deadzone(dz_list[i]);
      send_sample(16'sd32767, 16'sd0);
      send_sample(-16'sd32768, 16'sd32767);
      send_sample(16'sd1, 16'sd0);
      random_burst(60);
      wait_drained();
    end
    write_deadzone(DZ_RESET);
  endtask

  task automatic test_back_pressure();
    hold_off = 200;
    random_burst(120);
    wait_drained();
  endtask

  task automatic test_random_stream();
    random_burst(400);
    stall_enable = 1'b0;
    random_burst(100);
    stall_enable = 1'b1;
    wait_drained();
    write_deadzone(15'($urandom_range(0, 32767)));
    random_burst(120);
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_deadzone_settings();
    test_back_pressure();
    test_random_stream();
    $display("covered %0d samples, %0d results, deadzone from 0 to 32767, with stalls",
             samples_sent, results_seen);
    if (errors == 0) begin
      $display("stick_radial_deadzone_quantizer regression: pass");
    end else begin
      $display("stick_radial_deadzone_quantizer regression: fail");
    end
    $finish;
  end
endmodule

// ----- files.f -----
sv/srdq_pkg.sv
sv/srdq_if.sv
sv/srdq_sqrt.sv
sv/srdq_div.sv
sv/stick_radial_deadzone_quantizer.sv
test/tb_stick_radial_deadzone_quantizer.sv
